>>> rtl/sorted_insert_priority_queue_top_defines.svh
// assertion macros for the sorted-insert priority queue
// used by the top level only, relies on clk and arst_n in the including scope
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");
`else
`define SPQ_ASSERT_IMPL(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/spq_pkg.sv
// shared constants and types of the sorted-insert priority queue
// no dependencies
package spq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int FREQ_WIDTH_DEF = 32;
	localparam int SYM_W          = 8;
	localparam int CAP_W          = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// row-wide command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_op_t;

endpackage

>>> rtl/spq_if.sv
// valid/ready channel interfaces: request, response and capacity write
// depends on spq_pkg
interface spq_in_if #(
	parameter int FREQ_WIDTH = spq_pkg::FREQ_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [spq_pkg::SYM_W-1:0]   in_symbol;
	logic [FREQ_WIDTH-1:0]       in_frequency;

	modport source (output valid, cmd, in_symbol, in_frequency, input ready);
	modport sink   (input valid, cmd, in_symbol, in_frequency, output ready);
endinterface

interface spq_out_if #(
	parameter int FREQ_WIDTH = spq_pkg::FREQ_WIDTH_DEF,
	parameter int CNT_W      = $clog2(spq_pkg::DEPTH_DEF + 1)
);
	logic                        valid;
	logic                        ready;
	logic                        ok;
	logic [spq_pkg::SYM_W-1:0]   out_symbol;
	logic [FREQ_WIDTH-1:0]       out_frequency;
	logic [CNT_W-1:0]            count;
	logic                        is_empty;
	logic                        is_full;

	modport source (output valid, ok, out_symbol, out_frequency, count, is_empty, is_full,
		input ready);
	modport sink   (input valid, ok, out_symbol, out_frequency, count, is_empty, is_full,
		output ready);
endinterface

interface spq_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [spq_pkg::CAP_W-1:0]   capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

>>> rtl/spq_cell.sv
// one slot of the sorted row: holds an entry, compares it with the new key
// and takes the new entry or a neighbor's entry; depends on spq_pkg
module spq_cell #(
	parameter int FREQ_WIDTH = spq_pkg::FREQ_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spq_pkg::spq_op_t          op,
	input  logic [spq_pkg::SYM_W-1:0] new_sym,
	input  logic [FREQ_WIDTH-1:0]     new_freq,
	input  logic                      left_keep,
	input  logic                      left_valid,
	input  logic [spq_pkg::SYM_W-1:0] left_sym,
	input  logic [FREQ_WIDTH-1:0]     left_freq,
	input  logic                      right_valid,
	input  logic [spq_pkg::SYM_W-1:0] right_sym,
	input  logic [FREQ_WIDTH-1:0]     right_freq,
	output logic                      keep,
	output logic                      valid,
	output logic [spq_pkg::SYM_W-1:0] sym,
	output logic [FREQ_WIDTH-1:0]     freq
);

	logic                      valid_q;
	logic [spq_pkg::SYM_W-1:0] sym_q;
	logic [FREQ_WIDTH-1:0]     freq_q;

	logic                      valid_d;
	logic [spq_pkg::SYM_W-1:0] sym_d;
	logic [FREQ_WIDTH-1:0]     freq_d;

	// equal keys stay ahead of the newcomer
	assign keep = valid_q && (freq_q <= new_freq);

	always_comb begin
		valid_d = valid_q;
		sym_d   = sym_q;
		freq_d  = freq_q;
		if (op.enq && !keep) begin
			if (left_keep) begin
				valid_d = 1'b1;
				sym_d   = new_sym;
				freq_d  = new_freq;
			end else begin
				valid_d = left_valid;
				sym_d   = left_sym;
				freq_d  = left_freq;
			end
		end else if (op.deq) begin
			valid_d = right_valid;
			sym_d   = right_sym;
			freq_d  = right_freq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		sym_q  <= sym_d;
		freq_q <= freq_d;
	end

	assign valid = valid_q;
	assign sym   = sym_q;
	assign freq  = freq_q;

endmodule

>>> rtl/spq_ctrl.sv
// handshake, count, capacity register and result register of the queue
// depends on spq_pkg and spq_if
module spq_ctrl #(
	parameter int DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int FREQ_WIDTH = spq_pkg::FREQ_WIDTH_DEF,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	spq_in_if.sink                    req,
	spq_out_if.source                 rsp,
	spq_cfg_if.sink                   cfg,
	input  logic [spq_pkg::SYM_W-1:0] head_sym,
	input  logic [FREQ_WIDTH-1:0]     head_freq,
	output spq_pkg::spq_op_t          op,
	output logic [CNT_W-1:0]          cnt
);

	localparam int CMP_W = (CNT_W > spq_pkg::CAP_W) ? CNT_W : spq_pkg::CAP_W;

	logic [spq_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]          count_q;
	logic                      rsp_valid_q;
	logic                      ok_q;
	logic [spq_pkg::SYM_W-1:0] sym_q;
	logic [FREQ_WIDTH-1:0]     freq_q;
	logic [CNT_W-1:0]          rsp_count_q;
	logic                      empty_q;
	logic                      full_q;

	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;
	logic [CMP_W-1:0] cnt_next_ext;
	logic [CNT_W-1:0] count_d;
	logic             acc;
	logic             full_now;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;
	assign acc       = req.valid && req.ready;

	always_comb begin
		cap_ext  = CMP_W'(capacity_q);
		// capacity above the built depth saturates
		eff_cap  = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
		full_now = CMP_W'(count_q) >= eff_cap;
		op.enq   = acc && (req.cmd == spq_pkg::CMD_ENQ) && !full_now;
		op.deq   = acc && (req.cmd == spq_pkg::CMD_DEQ) && (count_q != '0);
		if (op.enq) begin
			count_d = count_q + CNT_W'(1);
		end else if (op.deq) begin
			count_d = count_q - CNT_W'(1);
		end else begin
			count_d = count_q;
		end
		cnt_next_ext = CMP_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= spq_pkg::CAP_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				capacity_q <= cfg.capacity;
			end
			count_q <= count_d;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_q        <= op.enq || op.deq;
			sym_q       <= op.deq ? head_sym : '0;
			freq_q      <= op.deq ? head_freq : '0;
			rsp_count_q <= count_d;
			empty_q     <= count_d == '0;
			full_q      <= cnt_next_ext >= eff_cap;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.ok            = ok_q;
	assign rsp.out_symbol    = sym_q;
	assign rsp.out_frequency = freq_q;
	assign rsp.count         = rsp_count_q;
	assign rsp.is_empty      = empty_q;
	assign rsp.is_full       = full_q;
	assign cnt               = count_q;

endmodule

>>> rtl/sorted_insert_priority_queue_top.sv
// sorted-insert priority queue: a row of DEPTH cells kept in ascending frequency order
// the result is registered and shows in the cycle after the request transfer
// throughput: one request per cycle while results are taken; every cell compares
// its key with the new one in the same cycle and shifts one place left or right
// reset clears the count, cell valid bits and result valid, capacity returns to 16
// depends on spq_pkg, spq_if, spq_cell, spq_ctrl and the defines header
`include "sorted_insert_priority_queue_top_defines.svh"
module sorted_insert_priority_queue_top #(
	parameter int DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int FREQ_WIDTH = spq_pkg::FREQ_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_in_if.sink    req,
	spq_out_if.source rsp,
	spq_cfg_if.sink   cfg
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	spq_pkg::spq_op_t          op;
	logic [CNT_W-1:0]          cnt;
	logic [DEPTH-1:0]          valid_v;
	logic [DEPTH:0]            keep_v;
	logic [spq_pkg::SYM_W-1:0] sym_a  [DEPTH];
	logic [FREQ_WIDTH-1:0]     freq_a [DEPTH];

	// the head cell takes the new entry whenever it does not keep its own
	assign keep_v[0] = 1'b1;

	spq_ctrl #(
		.DEPTH      (DEPTH),
		.FREQ_WIDTH (FREQ_WIDTH),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.head_sym  (sym_a[0]),
		.head_freq (freq_a[0]),
		.op        (op),
		.cnt       (cnt)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      l_valid;
		logic [spq_pkg::SYM_W-1:0] l_sym;
		logic [FREQ_WIDTH-1:0]     l_freq;
		logic                      r_valid;
		logic [spq_pkg::SYM_W-1:0] r_sym;
		logic [FREQ_WIDTH-1:0]     r_freq;

		if (i == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_sym   = '0;
			assign l_freq  = '0;
		end else begin : g_left
			assign l_valid = valid_v[i-1];
			assign l_sym   = sym_a[i-1];
			assign l_freq  = freq_a[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_sym   = '0;
			assign r_freq  = '0;
		end else begin : g_right
			assign r_valid = valid_v[i+1];
			assign r_sym   = sym_a[i+1];
			assign r_freq  = freq_a[i+1];
		end

		spq_cell #(
			.FREQ_WIDTH (FREQ_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.new_sym     (req.in_symbol),
			.new_freq    (req.in_frequency),
			.left_keep   (keep_v[i]),
			.left_valid  (l_valid),
			.left_sym    (l_sym),
			.left_freq   (l_freq),
			.right_valid (r_valid),
			.right_sym   (r_sym),
			.right_freq  (r_freq),
			.keep        (keep_v[i+1]),
			.valid       (valid_v[i]),
			.sym         (sym_a[i]),
			.freq        (freq_a[i])
		);
	end

	// occupied cells form a prefix of the row and match the count
	`SPQ_ASSERT_IMPL(a_valid_prefix, 1'b1, ((valid_v & (valid_v + 1'b1)) == '0))
	`SPQ_ASSERT_IMPL(a_valid_count, 1'b1, ($countones(valid_v) == int'(cnt)))
	// the two front entries are in order
	`SPQ_ASSERT_IMPL(a_head_sorted, valid_v[1], (freq_a[0] <= freq_a[1]))
	`SPQ_ASSERT_NEXT(a_enq_count, op.enq, (cnt == $past(cnt) + 1'b1))

endmodule

>>> dv/tb_top.sv
// self-checking bench for the sorted-insert priority queue
// runs a directed table, then random enqueue/dequeue phases under changing capacities
// depends on spq_pkg, spq_if and sorted_insert_priority_queue_top
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FW          = spq_pkg::FREQ_WIDTH_DEF;
	localparam int DEPTH       = spq_pkg::DEPTH_DEF;
	localparam int CAP_W       = spq_pkg::CAP_W;
	localparam int N_ITEMS     = 1850;
	localparam int HOLD_CYCLES = 120;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic          ok;
		logic [7:0]    symbol;
		logic [FW-1:0] frequency;
		logic [4:0]    count;
		logic          empty;
		logic          full;
	} qrsp_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             cmd;
		logic [7:0]       symbol;
		logic [FW-1:0]    frequency;
		logic [CAP_W-1:0] capacity;
		logic             pinned;
		qrsp_t            result;
	} row_t;

	localparam qrsp_t NO_PIN = '0;

	// fixed results are given only where they follow directly from reset, limits or refusals
	localparam row_t DIRECTED [24] = '{
		'{ROW_REQ, spq_pkg::CMD_DEQ, 8'h00, 32'h0000_0000, 5'd0, 1'b1,
			'{1'b0, 8'h00, 32'h0, 5'd0, 1'b1, 1'b0}},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'hFF, 32'hFFFF_FFFF, 5'd0, 1'b1,
			'{1'b1, 8'h00, 32'h0, 5'd1, 1'b0, 1'b0}},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'h00, 32'h0000_0000, 5'd0, 1'b1,
			'{1'b1, 8'h00, 32'h0, 5'd2, 1'b0, 1'b0}},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'h41, 32'h0000_0005, 5'd0, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'h42, 32'h0000_0005, 5'd0, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_DEQ, 8'h00, 32'h0000_0000, 5'd0, 1'b1,
			'{1'b1, 8'h00, 32'h0, 5'd3, 1'b0, 1'b0}},
		'{ROW_REQ, spq_pkg::CMD_DEQ, 8'h00, 32'h0000_0000, 5'd0, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_DEQ, 8'h00, 32'h0000_0000, 5'd0, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_DEQ, 8'h00, 32'h0000_0000, 5'd0, 1'b1,
			'{1'b1, 8'hFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0}},
		'{ROW_CFG, spq_pkg::CMD_ENQ, 8'h00, 32'h0000_0000, 5'd0, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'h13, 32'h0000_0009, 5'd0, 1'b1,
			'{1'b0, 8'h00, 32'h0, 5'd0, 1'b1, 1'b1}},
		'{ROW_REQ, spq_pkg::CMD_DEQ, 8'h00, 32'h0000_0000, 5'd0, 1'b1,
			'{1'b0, 8'h00, 32'h0, 5'd0, 1'b1, 1'b1}},
		'{ROW_CFG, spq_pkg::CMD_ENQ, 8'h00, 32'h0000_0000, 5'd1, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'h5A, 32'h8000_0000, 5'd0, 1'b1,
			'{1'b1, 8'h00, 32'h0, 5'd1, 1'b0, 1'b1}},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'hA5, 32'h0000_0001, 5'd0, 1'b1,
			'{1'b0, 8'h00, 32'h0, 5'd1, 1'b0, 1'b1}},
		'{ROW_CFG, spq_pkg::CMD_ENQ, 8'h00, 32'h0000_0000, 5'd31, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'h3C, 32'h0000_0007, 5'd0, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'hC3, 32'h0000_0003, 5'd0, 1'b0, NO_PIN},
		'{ROW_CFG, spq_pkg::CMD_ENQ, 8'h00, 32'h0000_0000, 5'd2, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_ENQ, 8'h77, 32'h0000_0000, 5'd0, 1'b1,
			'{1'b0, 8'h00, 32'h0, 5'd3, 1'b0, 1'b1}},
		'{ROW_REQ, spq_pkg::CMD_DEQ, 8'h00, 32'h0000_0000, 5'd0, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_DEQ, 8'h00, 32'h0000_0000, 5'd0, 1'b0, NO_PIN},
		'{ROW_CFG, spq_pkg::CMD_ENQ, 8'h00, 32'h0000_0000, 5'd16, 1'b0, NO_PIN},
		'{ROW_REQ, spq_pkg::CMD_DEQ, 8'h00, 32'h0000_0000, 5'd0, 1'b0, NO_PIN}
	};

	logic clk = 1'b0;
	logic arst_n;

	spq_in_if  #(.FREQ_WIDTH(FW)) req_ch ();
	spq_out_if #(.FREQ_WIDTH(FW)) rsp_ch ();
	spq_cfg_if                    cfg_ch ();

	sorted_insert_priority_queue_top #(
		.DEPTH(DEPTH),
		.FREQ_WIDTH(FW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the queue contents, kept sorted like the block's cells
	logic [7:0]       model_sym [DEPTH];
	logic [FW-1:0]    model_freq [DEPTH];
	int               model_count;
	logic [CAP_W-1:0] model_cap;

	qrsp_t pending_results [$];
	int    mismatches;
	int    items_sent;
	int    cycle_count;
	bit    quiet;
	bit    hold_rsp;

	function automatic qrsp_t predict_outcome(logic c, logic [7:0] s, logic [FW-1:0] f);
		qrsp_t r;
		int    lim;
		int    pos;
		r = '0;
		lim = (model_cap > DEPTH) ? DEPTH : int'(model_cap);
		if (c == spq_pkg::CMD_ENQ) begin
			if (model_count < lim) begin
				pos = 0;
				// equal keys stay ahead of the newcomer
				while (pos < model_count && model_freq[pos] <= f)
					pos++;
				for (int k = model_count; k > pos; k--) begin
					model_sym[k] = model_sym[k-1];
					model_freq[k] = model_freq[k-1];
				end
				model_sym[pos] = s;
				model_freq[pos] = f;
				model_count++;
				r.ok = 1'b1;
			end
		end else if (model_count > 0) begin
			r.ok = 1'b1;
			r.symbol = model_sym[0];
			r.frequency = model_freq[0];
			for (int k = 1; k < model_count; k++) begin
				model_sym[k-1] = model_sym[k];
				model_freq[k-1] = model_freq[k];
			end
			model_count--;
		end
		r.count = model_count[4:0];
		r.empty = (model_count == 0);
		r.full = (model_count >= lim);
		return r;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [FW-1:0] pick_freq(int mode);
		case (mode)
			0: return FW'($urandom_range(0, 7));
			1: return FW'($urandom());
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return FW'(1);
					default: return {{(FW-1){1'b1}}, 1'b0};
				endcase
			end
		endcase
	endfunction

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	task automatic send_op(logic c, logic [7:0] s, logic [FW-1:0] f, logic pin, qrsp_t fixed);
		int    gap;
		qrsp_t predicted;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.in_symbol <= s;
		req_ch.in_frequency <= f;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = predict_outcome(c, s, f);
		pending_results.push_back(pin ? fixed : predicted);
		items_sent++;
	endtask

	// capacity changes only once every result has drained
	task automatic write_capacity(logic [CAP_W-1:0] v);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.capacity <= v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		model_cap = v;
		cfg_ch.valid <= 1'b0;
	endtask

	// response side: random back-pressure, one long hold on request
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				stall = HOLD_CYCLES;
				hold_rsp = 1'b0;
			end else begin
				stall = quiet ? 0 : pick_gap();
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		qrsp_t want;
		qrsp_t got;
		string exp_s;
		string got_s;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = '{rsp_ch.ok, rsp_ch.out_symbol, rsp_ch.out_frequency, rsp_ch.count,
				rsp_ch.is_empty, rsp_ch.is_full};
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result transfer: ok=%0d sym=%02h freq=%08h",
					got.ok, got.symbol, got.frequency));
			end else begin
				want = pending_results.pop_front();
				if (got.ok !== want.ok || got.symbol !== want.symbol
						|| got.frequency !== want.frequency || got.count !== want.count
						|| got.empty !== want.empty || got.full !== want.full) begin
					exp_s = $sformatf("ok=%0d sym=%02h freq=%08h cnt=%0d emp=%0d full=%0d",
						want.ok, want.symbol, want.frequency, want.count, want.empty,
						want.full);
					got_s = $sformatf("ok=%0d sym=%02h freq=%08h cnt=%0d emp=%0d full=%0d",
						got.ok, got.symbol, got.frequency, got.count, got.empty,
						got.full);
					flag_error({"mismatch: exp ", exp_s, ", got ", got_s});
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int enq_pct;
		int fmode;
		int r;
		logic [CAP_W-1:0] cap;
		logic c;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = spq_pkg::CMD_ENQ;
		req_ch.in_symbol = '0;
		req_ch.in_frequency = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.capacity = spq_pkg::CAP_RESET;
		model_count = 0;
		model_cap = spq_pkg::CAP_RESET;
		mismatches = 0;
		items_sent = 0;
		cycle_count = 0;
		quiet = 1'b0;
		hold_rsp = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG)
				write_capacity(DIRECTED[i].capacity);
			else
				send_op(DIRECTED[i].cmd, DIRECTED[i].symbol, DIRECTED[i].frequency,
					DIRECTED[i].pinned, DIRECTED[i].result);
		end

		// keep offering enqueues while the response side is held, so the input stalls
		write_capacity(spq_pkg::CAP_RESET);
		quiet = 1'b1;
		hold_rsp = 1'b1;
		repeat (40)
			send_op(spq_pkg::CMD_ENQ, 8'($urandom_range(0, 255)), pick_freq(1), 1'b0, NO_PIN);

		while (items_sent < N_ITEMS) begin
			r = $urandom_range(0, 9);
			case (r)
				0: cap = 5'd0;
				1: cap = 5'd1;
				2: cap = 5'd16;
				3: cap = 5'd31;
				default: cap = CAP_W'($urandom_range(2, 20));
			endcase
			write_capacity(cap);
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: enq_pct = 30;
				1: enq_pct = 50;
				default: enq_pct = 75;
			endcase
			fmode = $urandom_range(0, 2);
			repeat ($urandom_range(30, 100)) begin
				c = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
				send_op(c, 8'($urandom_range(0, 255)), pick_freq(fmode), 1'b0, NO_PIN);
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/spq_ctrl.sv
rtl/sorted_insert_priority_queue_top.sv
dv/tb_top.sv
